FILE: hdl/smvg_pkg.sv
// smvg_pkg: shared types, constants and table functions for the sway mesh vertex generator
// no dependencies; imported by every module of the block

package smvg_pkg;

  localparam int STRIPS_DEF      = 8;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int QUEUE_DEPTH     = 8;

  // plant kind amplitudes, Q1.14
  localparam logic [14:0] KAMP_TREE  = 15'd24576;
  localparam logic [14:0] KAMP_YOUNG = 15'd16384;
  localparam logic [14:0] KAMP_SHRUB = 15'd9011;

  // weather scale bases, Q2.14
  localparam logic [15:0] SCALE_OPEN = 16'd5734;
  localparam logic [15:0] SCALE_SHEL = 16'd2867;

  localparam int WIND_CAP   = 40;
  localparam int PRECIP_CAP = 4;

  // reciprocal of 100 for the shelter term, exact below 2^19
  localparam logic [19:0] RECIP100    = 20'd671089;
  localparam int          RECIP100_SH = 26;
  // reciprocal of 6283 (underestimate) for the phase remainder
  localparam logic [19:0] RECIP6283   = 20'd683585;
  localparam logic [12:0] PHASE_MOD   = 13'd6283;

  localparam logic [27:0] TURN_PER_MRAD = 28'd174992711;
  localparam logic [29:0] TURN_PER_MS   = 30'd734969384;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [25:0] OUT_MAX = 26'sd8388607;
  localparam logic signed [25:0] OUT_MIN = -26'sd8388608;

  typedef struct packed {
    logic [2:0]         plant_flags;
    logic signed [31:0] tile_x;
    logic signed [31:0] tile_y;
    logic signed [31:0] anim_ms;
    logic [7:0]         wind_mph;
    logic [3:0]         rain_rank;
    logic               sheltered;
    logic signed [23:0] rect_left;
    logic signed [23:0] rect_top;
    logic signed [23:0] rect_width;
    logic signed [23:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic               tex_u;
    logic [3:0]         row_index;
    logic               last;
  } out_item_t;

  // one classified request, handed from front to back
  typedef struct packed {
    logic [44:0]        p;      // amplitude times sine magnitude
    logic [49:0]        mag;    // p times strips (row 0)
    logic [11:0]        dx;     // row 0 shift magnitude
    logic               neg;
    logic signed [23:0] left;
    logic signed [24:0] leftw;
    logic signed [23:0] top;
    logic [22:0]        hq;     // height / strips
    logic [4:0]         hr;     // height % strips
  } desc_t;

  function automatic logic [14:0] wind_term_f(input int w);
    return 15'((w * 57344 + 50) / 100);
  endfunction

  function automatic logic [12:0] precip_term_f(input int p);
    return 13'((p * 16384 + 5) / 10);
  endfunction

  // quarter wave sine magnitude, Q0.15, for step k of a table of 2^lg entries
  function automatic logic [14:0] qsine_f(input int unsigned k, input int unsigned lg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(k) * 64'd4 * HALF_PI_Q30) >> lg;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    // taylor terms from the highest order down
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd210);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s = (x * t) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic logic signed [23:0] sat24_f(input logic signed [25:0] v);
    if (v > OUT_MAX) begin
      return 24'sh7FFFFF;
    end else if (v < OUT_MIN) begin
      return -24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

FILE: hdl/smvg_front.sv
// smvg_front: classifies a request and works out amplitude, phase, sine and row 0 shift
// depends on smvg_pkg (types, weather and sine tables)

module smvg_front #(
  parameter int STRIPS     = smvg_pkg::STRIPS_DEF,
  parameter int SINE_DEPTH = smvg_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  smvg_pkg::in_item_t item,
  output logic               push,
  output smvg_pkg::desc_t    desc,
  output logic [3:0]         inflight
);
  import smvg_pkg::*;

  localparam int LG = $clog2(SINE_DEPTH);
  localparam int QN = SINE_DEPTH / 4;
  localparam logic [29:0] KH   = 30'((2 ** 29 + STRIPS - 1) / STRIPS);
  localparam logic [20:0] KD   = 21'((2 ** 20 + STRIPS - 1) / STRIPS);
  localparam logic [50:0] BIAS = 51'(STRIPS) << 38;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [24:0] leftw;
    logic signed [23:0] top;
    logic [22:0]        hq;
    logic [4:0]         hr;
    logic               neg;
  } pass_t;

  // constant tables
  logic [14:0] wtab [WIND_CAP + 1];
  logic [12:0] ptab [PRECIP_CAP + 1];
  logic [14:0] qtab [QN + 1];

  for (genvar k = 0; k <= WIND_CAP; k++) begin : g_wtab
    localparam logic [14:0] WV = wind_term_f(k);
    assign wtab[k] = WV;
  end
  for (genvar k = 0; k <= PRECIP_CAP; k++) begin : g_ptab
    localparam logic [12:0] PV = precip_term_f(k);
    assign ptab[k] = PV;
  end
  for (genvar k = 0; k <= QN; k++) begin : g_qtab
    localparam logic [14:0] QV = qsine_f(k, LG);
    assign qtab[k] = QV;
  end

  logic [9:1]  v_r;
  pass_t       ps_r [1:9];

  // stage 1
  logic [14:0]        kamp1_r;
  logic [14:0]        gust1_r;
  logic               shel1_r;
  logic [31:0]        seed1_r;
  logic [31:0]        el1_r;
  logic [22:0]        h1_r;
  // stage 2
  logic [14:0]        kamp2_r;
  logic [15:0]        scale2_r;
  logic [31:0]        seed2_r;
  logic [19:0]        q2_r;
  logic [31:0]        tturn2_r;
  logic [22:0]        h2_r;
  // stage 3
  logic [29:0]        amp3_r;
  logic [13:0]        r3_r;
  logic [31:0]        tturn3_r;
  // stage 4
  logic [29:0]        amp4_r;
  logic [31:0]        tturn4_r;
  logic [31:0]        phturn4_r;
  // stage 5..9
  logic [29:0]        amp5_r;
  logic [14:0]        smag5_r;
  logic [44:0]        p6_r;
  logic [44:0]        p7_r;
  logic [49:0]        mag7_r;
  logic [44:0]        p8_r;
  logic [49:0]        mag8_r;
  logic [11:0]        a8_r;
  logic [44:0]        p9_r;
  logic [49:0]        mag9_r;
  logic [11:0]        dx9_r;

  // stage 1 logic
  logic               flag_ok;
  logic [14:0]        kamp_sel;
  logic [5:0]         wsel;
  logic [2:0]         psel;
  always_comb begin
    flag_ok  = 1'b1;
    kamp_sel = KAMP_SHRUB;
    if (item.plant_flags[0]) begin
      kamp_sel = KAMP_TREE;
    end else if (item.plant_flags[1]) begin
      kamp_sel = KAMP_YOUNG;
    end else if (!item.plant_flags[2]) begin
      flag_ok = 1'b0;
    end
    wsel = (item.wind_mph > 8'(WIND_CAP)) ? 6'(WIND_CAP) : item.wind_mph[5:0];
    psel = (item.rain_rank > 4'(PRECIP_CAP)) ? 3'(PRECIP_CAP) : item.rain_rank[2:0];
  end

  // stage 2 logic
  logic [18:0] shn;
  logic [38:0] shprod;
  logic [51:0] qprod;
  logic [61:0] tprod;
  logic [52:0] hprod;
  assign shn    = 19'(gust1_r) * 19'd15 + 19'd50;
  assign shprod = 39'(shn) * 39'(RECIP100);
  assign qprod  = 52'(seed1_r) * 52'(RECIP6283);
  // time is signed: sign-extend so the floor shift keeps the right turn bits
  assign tprod  = {{30{el1_r[31]}}, el1_r} * 62'(TURN_PER_MS);
  assign hprod  = 53'(h1_r) * 53'(KH);

  // stage 3 logic
  logic [30:0] aprod;
  logic [31:0] qmul;
  logic [27:0] hqmul;
  assign aprod = 31'(kamp2_r) * 31'(scale2_r);
  assign qmul  = 32'(q2_r) * 32'(PHASE_MOD);
  assign hqmul = 28'(ps_r[2].hq) * 28'(STRIPS);

  // stage 4 logic
  logic [12:0] ph;
  logic [40:0] phprod;
  assign ph     = (r3_r >= 14'(PHASE_MOD)) ? 13'(r3_r - 14'(PHASE_MOD)) : r3_r[12:0];
  assign phprod = 41'(ph) * 41'(TURN_PER_MRAD);

  // stage 5 logic: quadrant fold into the quarter table
  logic [31:0]   angle;
  logic [LG-1:0] tidx;
  logic [1:0]    quad;
  logic [LG-2:0] qm;
  assign angle = tturn4_r + phturn4_r;
  assign tidx  = angle[31 -: LG];
  assign quad  = tidx[LG-1 -: 2];
  assign qm    = quad[0] ? ((LG-1)'(QN) - {1'b0, tidx[LG-3:0]}) : {1'b0, tidx[LG-3:0]};

  // stage 8/9 logic
  logic [50:0] bsum;
  logic [32:0] dprod;
  assign bsum  = 51'(mag7_r) + BIAS;
  assign dprod = 33'(a8_r) * 33'(KD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[8:1], acc & flag_ok & (item.rect_width > 0) & (item.rect_height > 0)};
    end
  end

  always_ff @(posedge clk) begin
    // pass-through fields; hq, hr and neg are filled in at stages 2, 3 and 5
    for (int k = 2; k <= 9; k++) begin
      ps_r[k].left  <= ps_r[k-1].left;
      ps_r[k].leftw <= ps_r[k-1].leftw;
      ps_r[k].top   <= ps_r[k-1].top;
      if (k != 2) begin
        ps_r[k].hq <= ps_r[k-1].hq;
      end
      if (k != 3) begin
        ps_r[k].hr <= ps_r[k-1].hr;
      end
      if (k != 5) begin
        ps_r[k].neg <= ps_r[k-1].neg;
      end
    end
    ps_r[1].left  <= item.rect_left;
    ps_r[1].leftw <= 25'(item.rect_left) + 25'(item.rect_width);
    ps_r[1].top   <= item.rect_top;
    ps_r[1].hq    <= '0;
    ps_r[1].hr    <= '0;
    ps_r[1].neg   <= 1'b0;

    kamp1_r <= kamp_sel;
    gust1_r <= wtab[wsel] + 15'(ptab[psel]);
    shel1_r <= item.sheltered;
    seed1_r <= item.tile_x + (item.tile_y <<< 16);
    el1_r   <= item.anim_ms;
    h1_r    <= item.rect_height[22:0];

    kamp2_r  <= kamp1_r;
    scale2_r <= shel1_r ? (SCALE_SHEL + 16'(shprod[38:RECIP100_SH]))
                        : (SCALE_OPEN + 16'(gust1_r));
    seed2_r  <= seed1_r;
    q2_r     <= qprod[51:32];
    tturn2_r <= tprod[39:8];
    h2_r     <= h1_r;
    ps_r[2].hq <= hprod[51:29];

    amp3_r   <= aprod[29:0];
    r3_r     <= 14'(seed2_r - qmul);
    tturn3_r <= tturn2_r;
    ps_r[3].hr <= 5'(h2_r - 23'(hqmul));

    amp4_r    <= amp3_r;
    tturn4_r  <= tturn3_r;
    phturn4_r <= phprod[39:8];

    amp5_r  <= amp4_r;
    smag5_r <= qtab[qm];
    ps_r[5].neg <= quad[1];

    p6_r   <= 45'(amp5_r) * 45'(smag5_r);

    p7_r   <= p6_r;
    mag7_r <= 50'(p6_r) * 50'(STRIPS);

    p8_r   <= p7_r;
    mag8_r <= mag7_r;
    a8_r   <= bsum[50:39];

    p9_r   <= p8_r;
    mag9_r <= mag8_r;
    dx9_r  <= dprod[31:20];
  end

  assign push     = v_r[9];
  assign inflight = 4'($countones(v_r));

  always_comb begin
    desc.p     = p9_r;
    desc.mag   = mag9_r;
    desc.dx    = dx9_r;
    desc.neg   = ps_r[9].neg;
    desc.left  = ps_r[9].left;
    desc.leftw = ps_r[9].leftw;
    desc.top   = ps_r[9].top;
    desc.hq    = ps_r[9].hq;
    desc.hr    = ps_r[9].hr;
  end

endmodule

FILE: hdl/smvg_queue.sv
// smvg_queue: small first-in first-out queue of classified requests
// depends on smvg_pkg (desc_t)

module smvg_queue #(
  parameter int DEPTH = smvg_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  smvg_pkg::desc_t            wr_data,
  input  logic                       pop,
  output smvg_pkg::desc_t            rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import smvg_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  assign rd_data = mem[rd_ptr_r];
  assign count   = count_r;

endmodule

FILE: hdl/smvg_back.sv
// smvg_back: walks the rows of one request and emits a left and a right vertex per row
// depends on smvg_pkg (desc_t, out_item_t, saturation)

module smvg_back #(
  parameter int STRIPS = smvg_pkg::STRIPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  smvg_pkg::desc_t     q_data,
  output logic                pop,
  output logic                out_valid,
  output smvg_pkg::out_item_t out_item
);
  import smvg_pkg::*;

  localparam int RW = $clog2(STRIPS + 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(STRIPS);
  localparam logic [20:0]   KD       = 21'((2 ** 20 + STRIPS - 1) / STRIPS);
  localparam logic [50:0]   BIAS     = 51'(STRIPS) << 38;
  localparam logic [5:0]    STRIPS6  = 6'(STRIPS);
  localparam logic [5:0]    HALF6    = 6'(STRIPS / 2);

  logic          act_r;
  logic [RW-1:0] row_r;
  logic          side_r;
  desc_t         cur_r;
  logic [49:0]   mag_r;
  logic [11:0]   a_r;
  logic [11:0]   dx_r;
  logic [22:0]   yq_r;
  logic [5:0]    yr_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic              end_item;
  logic [49:0]       mag_nxt;
  logic [50:0]       bsum;
  logic [32:0]       dprod;
  logic [5:0]        yr_sum;
  logic signed [12:0] dxs;
  logic signed [25:0] xv;
  logic signed [25:0] yv;

  assign end_item = act_r & side_r & (row_r == ROW_LAST);
  assign pop      = q_valid & (!act_r | end_item);

  assign mag_nxt = mag_r - 50'(cur_r.p);
  assign bsum    = 51'(mag_nxt) + BIAS;
  assign dprod   = 33'(a_r) * 33'(KD);
  assign yr_sum  = yr_r + 6'(cur_r.hr);

  always_comb begin
    dxs = cur_r.neg ? -$signed({1'b0, dx_r}) : $signed({1'b0, dx_r});
    xv  = side_r ? (26'(cur_r.leftw) + 26'(dxs)) : (26'(cur_r.left) + 26'(dxs));
    yv  = 26'(cur_r.top) + $signed({3'b000, yq_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      side_r      <= 1'b0;
    end else begin
      out_valid_r <= act_r;
      if (pop) begin
        act_r  <= 1'b1;
        row_r  <= '0;
        side_r <= 1'b0;
      end else if (end_item) begin
        act_r <= 1'b0;
      end else if (act_r) begin
        side_r <= ~side_r;
        if (side_r) begin
          row_r <= row_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.vert_x    <= sat24_f(xv);
    out_r.vert_y    <= sat24_f(yv);
    out_r.tex_u     <= side_r;
    out_r.row_index <= 4'(row_r);
    out_r.last      <= end_item;
    if (pop) begin
      cur_r <= q_data;
      mag_r <= q_data.mag;
      dx_r  <= q_data.dx;
      yq_r  <= '0;
      yr_r  <= HALF6;
    end else if (act_r) begin
      if (!side_r) begin
        // next row shift, first half: quotient by 2^39, biased by half of strips times 2^39
        mag_r <= mag_nxt;
        a_r   <= bsum[50:39];
      end else begin
        // second half: divide by strips, and step y
        dx_r <= dprod[31:20];
        if (yr_sum >= STRIPS6) begin
          yq_r <= yq_r + cur_r.hq + 23'd1;
          yr_r <= yr_sum - STRIPS6;
        end else begin
          yq_r <= yq_r + cur_r.hq;
          yr_r <= yr_sum;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: hdl/sway_mesh_vertex_generator.sv
// a request passes the front pipeline, a queue slot, the walker's request and output registers;
//   its 2*(STRIPS+1) vertices follow 1 per cycle from the vertex walker, which takes the next
//   request on the last vertex; requests with no plant or an empty rectangle are dropped at the front
// busy rises once the front pipeline and the request queue together hold QUEUE_DEPTH requests
// reset: synchronous active-low rst_n empties pipeline, queue and walker; no strobe after it
// the receiver cannot stall: each vertex strobe lasts exactly one cycle

module sway_mesh_vertex_generator #(
  parameter int STRIPS           = smvg_pkg::STRIPS_DEF,
  parameter int SINE_TABLE_DEPTH = smvg_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smvg_pkg::in_item_t  in_item,
  output logic                out_valid,
  output smvg_pkg::out_item_t out_item
);
  import smvg_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // front to queue transfer
  logic          push;
  desc_t         push_desc;
  logic [3:0]    inflight;

  // queue to back transfer
  logic          pop;
  desc_t         head_desc;
  logic [CW-1:0] q_count;

  logic          acc;
  logic [4:0]    occupancy;

  // requests in flight plus requests queued may not exceed the queue size,
  // so every request leaving the front always finds a free slot
  assign occupancy = 5'(inflight) + 5'(q_count);
  assign busy      = (occupancy >= 5'(QUEUE_DEPTH));
  assign acc       = start & ~busy;

  // front: classification, weather scale, phase, sine lookup, row 0 shift
  smvg_front #(
    .STRIPS     (STRIPS),
    .SINE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_item),
    .push     (push),
    .desc     (push_desc),
    .inflight (inflight)
  );

  // decouples the front pipeline from the vertex walker
  smvg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_desc),
    .pop     (pop),
    .rd_data (head_desc),
    .count   (q_count)
  );

  // back: one vertex per cycle while it holds a request, the next request is picked up on the last vertex
  smvg_back #(
    .STRIPS (STRIPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_count != '0),
    .q_data    (head_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: hdl/smvg_checker.sv
// smvg_assert: port-level checks of reset behaviour and of the vertex stream ordering
// depends on smvg_pkg (out_item_t); bound to sway_mesh_vertex_generator

module smvg_assert (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_valid,
  input smvg_pkg::out_item_t out_item
);

  // no strobe right after a reset edge
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("vertex strobe after reset");

  // the block is ready for a request right after a reset edge
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // a left vertex is followed by the right vertex of the same row
  a_left_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.tex_u |=> out_valid && out_item.tex_u &&
      out_item.row_index == $past(out_item.row_index) &&
      out_item.vert_y == $past(out_item.vert_y))
    else $error("left vertex not followed by matching right vertex");

  // a right vertex that is not last is followed by the next row's left vertex
  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.tex_u && !out_item.last |=> out_valid && !out_item.tex_u &&
      out_item.row_index == 4'($past(out_item.row_index) + 4'd1))
    else $error("row sequence broken");

  // the final vertex is a right vertex
  a_last_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.tex_u)
    else $error("last flag on a left vertex");

endmodule

bind sway_mesh_vertex_generator smvg_assert u_smvg_assert (.*);

FILE: tb/sv/smvg_checker.sv
// smvg_checker: watches the request and vertex channels of the sway mesh vertex generator,
// predicts every vertex from each accepted request and compares them in order
// depends on smvg_pkg for the channel structs

module smvg_checker #(
  parameter int STRIPS     = 8,
  parameter int SINE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  smvg_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  smvg_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  vert_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import smvg_pkg::*;

  logic signed [15:0] sine_lut [SINE_DEPTH];
  out_item_t          vert_fifo [$];

  function automatic logic [63:0] quarter_wave(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    for (int k = 7; k >= 1; k--) begin
      t = 64'd1073741824 - (((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1)));
    end
    return (x * t) >> 30;
  endfunction

  initial begin
    logic [63:0] q, r, m, v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      q = (64'd4 * i) / SINE_DEPTH;
      r = 64'd4 * i - q * SINE_DEPTH;
      m = q[0] ? (SINE_DEPTH - r) : r;
      v = (quarter_wave((m * 64'd1686629713) / SINE_DEPTH) * 64'd32767
           + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      sine_lut[i] = (q >= 2) ? -$signed({1'b0, v[14:0]}) : $signed({1'b0, v[14:0]});
    end
  end

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // expand one request into its vertex list
  task automatic predict_vertices(input in_item_t rq);
    longint unsigned kamp, wind, prec, gust, scale, amp, smag, den, mag;
    logic [31:0]     seed, ph_turn, t_turn, angle;
    logic [63:0]     prod;
    logic signed [15:0] s;
    longint          dx, y, w, h;
    out_item_t       o;
    if (rq.plant_flags[0]) kamp = 24576;
    else if (rq.plant_flags[1]) kamp = 16384;
    else if (rq.plant_flags[2]) kamp = 9011;
    else return;
    w = rq.rect_width;
    h = rq.rect_height;
    if (w <= 0 || h <= 0) return;
    wind = (rq.wind_mph > 40) ? 40 : rq.wind_mph;
    prec = (rq.rain_rank > 4) ? 4 : rq.rain_rank;
    gust = (wind * 57344 + 50) / 100 + (prec * 16384 + 5) / 10;
    scale = rq.sheltered ? 2867 + (gust * 15 + 50) / 100 : 5734 + gust;
    amp = kamp * scale;
    seed = rq.tile_x + rq.tile_y * 32'd65536;
    ph_turn = 32'(((64'(seed % 32'd6283)) * 64'd174992711) >> 8);
    prod = 64'($signed(rq.anim_ms)) * 64'd734969384;
    t_turn = 32'($signed(prod) >>> 8);
    angle = t_turn + ph_turn;
    s = sine_lut[(64'(angle) * SINE_DEPTH) >> 32];
    smag = (s < 0) ? -64'(s) : 64'(s);
    den = 64'(STRIPS) << 39;
    for (int row = 0; row <= STRIPS; row++) begin
      mag = amp * smag * (STRIPS - row);
      dx = (mag + den / 2) / den;
      if (s < 0) dx = -dx;
      y = longint'(rq.rect_top) + (h * row + STRIPS / 2) / STRIPS;
      for (int side = 0; side < 2; side++) begin
        o.vert_x    = clamp24(longint'(rq.rect_left) + (side ? w : 0) + dx);
        o.vert_y    = clamp24(y);
        o.tex_u     = side[0];
        o.row_index = row[3:0];
        o.last      = (row == STRIPS && side == 1);
        vert_fifo   = {vert_fifo, o};
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] vertex %0d: %s got %0d expected %0d", $time, vert_count, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fail_count = 0;
      vert_count = 0;
      vert_fifo.delete();
    end else begin
      if (start && !busy) predict_vertices(in_item);
      if (out_valid) begin
        if (vert_fifo.size() == 0) begin
          report_mismatch("unexpected vertex, x", out_item.vert_x, 0);
        end else begin
          want = vert_fifo.pop_front();
          if (out_item.vert_x !== want.vert_x)
            report_mismatch("vert_x", out_item.vert_x, want.vert_x);
          if (out_item.vert_y !== want.vert_y)
            report_mismatch("vert_y", out_item.vert_y, want.vert_y);
          if (out_item.tex_u !== want.tex_u) report_mismatch("tex_u", out_item.tex_u, want.tex_u);
          if (out_item.row_index !== want.row_index)
            report_mismatch("row_index", out_item.row_index, want.row_index);
          if (out_item.last !== want.last) report_mismatch("last", out_item.last, want.last);
        end
        vert_count++;
      end
    end
    pending = vert_fifo.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// testbench: stimulus and verdict for the sway mesh vertex generator
// depends on smvg_pkg, sway_mesh_vertex_generator and smvg_checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smvg_pkg::*;

  localparam int LIMIT = 200000;

  logic      clk, rst_n, start, busy, out_valid;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, pending, vert_count;
  int        cycles = 0;
  int        idle_pct = 0;   // chance in percent that the sender skips a cycle
  int        sent = 0;

  sway_mesh_vertex_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  smvg_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending(pending), .vert_count(vert_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("sway_mesh_vertex_generator verification failed");
      $finish;
    end
  end

  // random request, mostly drawable plants with small sane rectangles
  function automatic in_item_t rand_request();
    in_item_t r;
    r = '0;
    r.plant_flags = 3'($urandom_range(7));
    if ($urandom_range(9) < 8 && r.plant_flags == 0) r.plant_flags = 3'($urandom_range(1, 7));
    r.tile_x      = $urandom;
    r.tile_y      = $urandom;
    r.anim_ms     = $urandom;
    r.wind_mph    = 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(45));
    r.rain_rank   = 4'($urandom);
    r.sheltered   = 1'($urandom);
    r.rect_left   = 24'($urandom);
    r.rect_top    = 24'($urandom);
    case ($urandom_range(9))
      0: begin
        r.rect_width  = 24'($urandom);
        r.rect_height = 24'($urandom);
      end
      1: begin
        r.rect_width  = 24'(24'sh7FFFFF - $urandom_range(15));
        r.rect_height = 24'(24'sh7FFFFF - $urandom_range(15));
      end
      default: begin
        r.rect_width  = 24'($urandom_range(1, 4096));
        r.rect_height = 24'($urandom_range(1, 4096));
      end
    endcase
    return r;
  endfunction

  // one transfer: hold start until the block takes the request
  task automatic send(input in_item_t r);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= r;
    // busy is stable from one falling edge to the next rising edge
    do begin
      took = !busy;
      @(negedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    in_item_t r;
    start   = 1'b0;
    in_item = '0;
    rst_n   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: each plant kind, flag priority, empty cases, weather and coordinate extremes
    for (int f = 0; f < 8; f++) begin
      r = rand_request();
      r.plant_flags = f[2:0];
      r.rect_width  = 24'sd320;
      r.rect_height = 24'sd512;
      r.wind_mph    = (f[0]) ? 8'd255 : 8'd0;
      r.rain_rank   = (f[1]) ? 4'd15 : 4'd4;
      r.sheltered   = f[2];
      send(r);
    end
    r = rand_request(); r.plant_flags = 3'd1; r.rect_width = 24'sd0; send(r);
    r = rand_request(); r.plant_flags = 3'd1; r.rect_height = -24'sd1; send(r);
    r = rand_request(); r.plant_flags = 3'd2; r.rect_width = 24'sh800000; send(r);
    r = rand_request(); r.plant_flags = 3'd1; r.rect_width = 24'sd1; r.rect_height = 24'sd1;
    send(r);
    // saturation on both edges of the coordinate range
    r = rand_request(); r.plant_flags = 3'd1; r.wind_mph = 8'd40; r.rain_rank = 4'd4;
    r.sheltered = 1'b0; r.rect_left = 24'sh7FFFFF; r.rect_top = 24'sh7FFFF0;
    r.rect_width = 24'sh7FFFFF; r.rect_height = 24'sh7FFFFF; send(r);
    r.rect_left = 24'sh800000; r.rect_top = 24'sh800000; r.anim_ms = 32'sh80000000;
    send(r);
    r.tile_x = 32'sh7FFFFFFF; r.tile_y = 32'shFFFFFFFF; r.anim_ms = 32'sh7FFFFFFF; send(r);
    r.tile_x = 32'sh80000000; r.tile_y = 32'sh80000000; r.anim_ms = -32'sd1; send(r);
    r.tile_x = 0; r.tile_y = 0; r.anim_ms = 0; send(r);
    for (int t = 0; t < 4; t++) begin
      r = rand_request(); r.plant_flags = 3'd1; r.rect_width = 24'sd64; r.rect_height = 24'sd64;
      r.anim_ms = t * 374; send(r);
    end
    // quiet the block fully before the random phases
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 66 : (ph == 2) ? 23 : 0;
      for (int n = 0; n < 110; n++) send(rand_request());
      if (ph == 1) drain();
    end
    drain();

    $display("sent %0d requests, checked %0d vertices over idle mixes of 0, 23 and 66 percent",
             sent, vert_count);
    if (fail_count == 0) begin
      $display("sway_mesh_vertex_generator verification clean");
    end else begin
      $display("sway_mesh_vertex_generator verification failed");
    end
    $finish;
  end

endmodule
